// File: rtl/core/eoa_pkg.sv
// shared types and constants for the encoder offset alignment averager
// no dependencies; imported by eoa_divider and encoder_offset_align_averager
package eoa_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int TICK_BITS  = 24;
  localparam int CNT_BITS   = TICK_BITS + 1;
  localparam int SUM_BITS   = TICK_BITS + ANGLE_BITS;
  localparam int CFG_BITS   = (TICK_BITS > ANGLE_BITS) ? TICK_BITS : ANGLE_BITS;
  localparam int IDX_BITS   = 2;

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [CNT_BITS-1:0]   count_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [CFG_BITS-1:0]   cfg_data_t;
  typedef logic [IDX_BITS-1:0]   cfg_index_t;

  // register indexes
  localparam cfg_index_t REG_SETTLE_TICKS = 2'd0;
  localparam cfg_index_t REG_RAMP_TICKS   = 2'd1;
  localparam cfg_index_t REG_CARRIER_STEP = 2'd2;

  // register reset values
  localparam tick_t  SETTLE_RESET = 24'd10000;
  localparam tick_t  RAMP_RESET   = 24'd40000;
  localparam angle_t STEP_RESET   = 16'd66;

  typedef struct packed {
    logic   action;
    angle_t raw_angle;
  } tick_word_t;

  typedef struct packed {
    angle_t carrier_angle;
    logic   offset_valid;
    angle_t offset_angle;
    logic   done_res;
  } res_word_t;

endpackage

// File: rtl/core/eoa_divider.sv
// bit-serial signed-by-unsigned divider, truncating toward zero
// one quotient bit per cycle; depends on eoa_pkg
module eoa_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  eoa_pkg::sum_t   dividend,
  input  eoa_pkg::tick_t  divisor,
  output logic            done,
  output eoa_pkg::angle_t quotient
);
  import eoa_pkg::*;

  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_SIGN} dstate_t;

  dstate_t               dstate;
  logic [STEP_BITS-1:0]  steps;
  sum_t                  quo;
  sum_t                  quo_neg;
  sum_t                  dividend_mag;
  tick_t                 rem;
  tick_t                 dvs;
  logic                  neg;
  logic [TICK_BITS:0]    rem_sh;
  logic [TICK_BITS+1:0]  diff;

  assign rem_sh       = {rem, quo[SUM_BITS-1]};
  assign diff         = {1'b0, rem_sh} - {2'b00, dvs};
  assign quo_neg      = ~quo + SUM_BITS'(1);
  assign dividend_mag = dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (start) begin
            quo    <= dividend_mag;
            neg    <= dividend[SUM_BITS-1];
            rem    <= '0;
            dvs    <= divisor;
            steps  <= STEP_BITS'(SUM_BITS);
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          // restoring step: keep the shifted remainder on borrow
          if (diff[TICK_BITS+1]) begin
            rem <= rem_sh[TICK_BITS-1:0];
            quo <= {quo[SUM_BITS-2:0], 1'b0};
          end else begin
            rem <= diff[TICK_BITS-1:0];
            quo <= {quo[SUM_BITS-2:0], 1'b1};
          end
          steps <= steps - STEP_BITS'(1);
          if (steps == STEP_BITS'(1)) begin
            dstate <= D_SIGN;
          end
        end
        D_SIGN: begin
          quotient <= neg ? quo_neg[ANGLE_BITS-1:0] : quo[ANGLE_BITS-1:0];
          done     <= 1'b1;
          dstate   <= D_IDLE;
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/encoder_offset_align_averager.sv
// top level of the encoder offset alignment averager
// depends on eoa_pkg and eoa_divider
//
// usage:
//   tick channel: one word per control tick (action, raw_angle); valid/stall,
//   accepted when tick_valid is high and tick_stall is low
//   res channel: exactly one result word per tick (carrier_angle,
//   offset_valid, offset_angle, done_res); held while res_stall is high
//   cfg port: cfg_we writes cfg_data to register cfg_index (0 settle_ticks,
//   1 ramp_ticks, 2 carrier_step); other indexes are ignored, no read-back
// sequencing:
//   a settle, idle or sampleless completion tick goes through ST_EVAL and ST_FINISH,
//   a ramp tick through ST_EVAL, ST_SAMPLE and ST_FINISH; a completion with samples
//   runs the serial divider in ST_DIV, one quotient bit a cycle over 40 bits
//   one tick is in flight at a time; tick_stall is high until the result is
//   loaded into the output register, and the next tick may be accepted while
//   that result still waits on res_stall
// reset:
//   rst (synchronous) restores the register defaults and clears all
//   calibration state; a stalled receiver only delays the next result load
module encoder_offset_align_averager (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  eoa_pkg::tick_word_t tick,
  output logic                res_valid,
  input  logic                res_stall,
  output eoa_pkg::res_word_t  res,
  input  logic                cfg_we,
  input  eoa_pkg::cfg_index_t cfg_index,
  input  eoa_pkg::cfg_data_t  cfg_data
);
  import eoa_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_SAMPLE, ST_DIV, ST_FINISH} state_t;

  state_t state;

  // configuration registers
  tick_t  settle_ticks;
  tick_t  ramp_ticks;
  angle_t carrier_step;

  // calibration state
  count_t tick_count;
  angle_t carrier;
  angle_t anchor;
  sum_t   deviation_sum;
  tick_t  sample_count;
  angle_t offset_hold;
  logic   finished;

  // per-tick working registers
  angle_t raw;
  logic   valid_flag;

  // phase decode
  count_t ramp_end;
  logic   in_settle;
  logic   in_ramp;

  // sample path
  angle_t err;
  angle_t anchor_next;
  angle_t dev;
  sum_t   dev_ext;

  // divider hookup
  logic   div_start;
  logic   div_done;
  angle_t div_quotient;

  assign tick_stall = (state != ST_IDLE);

  assign ramp_end  = {1'b0, settle_ticks} + {1'b0, ramp_ticks};
  assign in_settle = tick_count < {1'b0, settle_ticks};
  assign in_ramp   = !in_settle && (tick_count < ramp_end);

  // completion with samples goes through the divider
  assign div_start = (state == ST_EVAL) && !in_settle && !in_ramp && !finished
                     && (sample_count != '0);

  // the anchor is the first error of the ramp
  assign err         = raw - carrier;
  assign anchor_next = (sample_count == '0) ? err : anchor;
  assign dev         = err - anchor_next;
  assign dev_ext     = {{(SUM_BITS - ANGLE_BITS){dev[ANGLE_BITS-1]}}, dev};

  eoa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (deviation_sum),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // configuration writes, accepted at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= SETTLE_RESET;
      ramp_ticks   <= RAMP_RESET;
      carrier_step <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETTLE_TICKS: settle_ticks <= cfg_data[TICK_BITS-1:0];
        REG_RAMP_TICKS:   ramp_ticks   <= cfg_data[TICK_BITS-1:0];
        REG_CARRIER_STEP: carrier_step <= cfg_data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      res_valid     <= 1'b0;
      valid_flag    <= 1'b0;
      tick_count    <= '0;
      carrier       <= '0;
      anchor        <= '0;
      deviation_sum <= '0;
      sample_count  <= '0;
      offset_hold   <= '0;
      finished      <= 1'b0;
    end else begin
      // result taken by the receiver; in ST_FINISH the load below covers it
      if (res_valid && !res_stall && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (tick_valid) begin
            raw <= tick.raw_angle;
            // restart clears the calibration before this tick's step
            if (tick.action) begin
              tick_count    <= '0;
              carrier       <= '0;
              anchor        <= '0;
              deviation_sum <= '0;
              sample_count  <= '0;
              offset_hold   <= '0;
              finished      <= 1'b0;
            end
            state <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          if (tick_count != '1) begin
            tick_count <= tick_count + CNT_BITS'(1);
          end
          if (in_settle) begin
            carrier <= '0;
            state   <= ST_FINISH;
          end else if (in_ramp) begin
            carrier <= carrier + carrier_step;
            state   <= ST_SAMPLE;
          end else if (!finished) begin
            if (sample_count == '0) begin
              // no samples: quotient is zero
              offset_hold <= anchor;
              finished    <= 1'b1;
              valid_flag  <= 1'b1;
              state       <= ST_FINISH;
            end else begin
              state <= ST_DIV;
            end
          end else begin
            state <= ST_FINISH;
          end
        end

        ST_SAMPLE: begin
          // sample count saturates, carrier keeps advancing
          if (sample_count != '1) begin
            anchor        <= anchor_next;
            deviation_sum <= deviation_sum + dev_ext;
            sample_count  <= sample_count + TICK_BITS'(1);
          end
          state <= ST_FINISH;
        end

        ST_DIV: begin
          if (div_done) begin
            offset_hold <= anchor + div_quotient;
            finished    <= 1'b1;
            valid_flag  <= 1'b1;
            state       <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // load the output register once it is free
          if (!res_valid || !res_stall) begin
            res_valid         <= 1'b1;
            res.carrier_angle <= carrier;
            res.offset_valid  <= valid_flag;
            res.offset_angle  <= offset_hold;
            res.done_res      <= finished;
            valid_flag        <= 1'b0;
            state             <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
